// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BTB2B_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTB2B_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/btb2b_pkg.sv =====
// ----------------------------------------------------------------------------
// btb2b_pkg
// Types and constants shared by the branch target buffer cells and top level.
// ----------------------------------------------------------------------------
package btb2b_pkg;

  localparam int unsigned CtrW   = 2;
  localparam logic [CtrW-1:0] CtrMax = 2'd3;
  localparam logic [CtrW-1:0] CtrMin = 2'd0;

  localparam logic OpPredict = 1'b0;
  localparam logic OpUpdate  = 1'b1;

  // Control part of the lookup token that walks the cell row.
  typedef struct packed {
    logic valid;
    logic update;
    logic taken;
    logic hit;
    logic pred_taken;
  } ctl_t;

endpackage

// ===== design/btb2b_cell.sv =====
// ----------------------------------------------------------------------------
// btb2b_cell
// One buffer entry plus one token stage: matches the passing token against
// the entry, trains the entry on an update hit, and takes broadcast fills.
// ----------------------------------------------------------------------------
module btb2b_cell #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   hold_i,
  input  btb2b_pkg::ctl_t        ctl_i,
  input  logic [ADDR_BITS-1:0]   pc_i,
  input  logic [ADDR_BITS-1:0]   tgt_i,
  input  logic [ADDR_BITS-1:0]   pred_tgt_i,
  output btb2b_pkg::ctl_t        ctl_o,
  output logic [ADDR_BITS-1:0]   pc_o,
  output logic [ADDR_BITS-1:0]   tgt_o,
  output logic [ADDR_BITS-1:0]   pred_tgt_o,
  input  logic                   fill_i,
  input  logic [ADDR_BITS-1:0]   fill_pc_i,
  input  logic [ADDR_BITS-1:0]   fill_tgt_i,
  input  logic                   fill_taken_i
);

  logic                            valid_q;
  logic [ADDR_BITS-1:0]            addr_q;
  logic [ADDR_BITS-1:0]            target_q;
  logic [btb2b_pkg::CtrW-1:0]      ctr_q;

  btb2b_pkg::ctl_t                 ctl_d, ctl_q;
  logic [ADDR_BITS-1:0]            pc_q, tgt_q, pred_tgt_q;
  logic [ADDR_BITS-1:0]            pred_tgt_d;
  logic                            match;

  // Only the first matching entry along the row claims the token.
  assign match = ctl_i.valid && valid_q && !ctl_i.hit && (addr_q == pc_i);

  always_comb begin
    ctl_d      = ctl_i;
    pred_tgt_d = pred_tgt_i;
    if (match) begin
      ctl_d.hit        = 1'b1;
      ctl_d.pred_taken = ctr_q[btb2b_pkg::CtrW-1];
      pred_tgt_d       = target_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      priority if (ctl_i.valid) begin
        ctl_q <= ctl_d;
      end else if (hold_i) begin
        ctl_q <= ctl_q;
      end else begin
        ctl_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      pc_q       <= pc_i;
      tgt_q      <= tgt_i;
      pred_tgt_q <= pred_tgt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fill_i) begin
      valid_q <= 1'b1;
    end
  end

  // Entry payload, trained on an update hit or overwritten by a fill.
  always_ff @(posedge clk_i) begin
    priority if (fill_i) begin
      addr_q   <= fill_pc_i;
      target_q <= fill_tgt_i;
      ctr_q    <= fill_taken_i ? btb2b_pkg::CtrMax : btb2b_pkg::CtrMin;
    end else if (match && (ctl_i.update == btb2b_pkg::OpUpdate)) begin
      target_q <= tgt_i;
      if (ctl_i.taken) begin
        if (ctr_q != btb2b_pkg::CtrMax) ctr_q <= ctr_q + 1'b1;
      end else begin
        if (ctr_q != btb2b_pkg::CtrMin) ctr_q <= ctr_q - 1'b1;
      end
    end else begin
      ctr_q <= ctr_q;
    end
  end

  assign ctl_o      = ctl_q;
  assign pc_o       = pc_q;
  assign tgt_o      = tgt_q;
  assign pred_tgt_o = pred_tgt_q;

endmodule

// ===== design/branch_target_buffer_2bit_unit.sv =====
// ----------------------------------------------------------------------------
// branch_target_buffer_2bit_unit
// Fully associative branch target buffer with 2-bit saturating counters.
// ----------------------------------------------------------------------------
// One beat is in flight at a time: the lookup token walks the row of entry
// cells one cell per cycle, waits in the last cell while the output
// register is full, then loads it, and a new beat is taken only once the
// row is empty. The result beat may wait in the output register while the
// next beat is taken.
// Every beat returns hit and the predicted next PC from the state before
// the beat; an update beat then trains the matching entry or, on a miss,
// fills the entry at the round-robin replacement pointer.
`include "assert_macros.svh"

module branch_target_buffer_2bit_unit #(
  parameter int unsigned ENTRIES   = 8,
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [15:0] branch_pc_i,
  input  logic [15:0] target_pc_i,
  input  logic        taken_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [15:0] predicted_pc_o
);

  localparam int unsigned PtrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  btb2b_pkg::ctl_t        ctl_chain      [ENTRIES+1];
  logic [ADDR_BITS-1:0]   pc_chain       [ENTRIES+1];
  logic [ADDR_BITS-1:0]   tgt_chain      [ENTRIES+1];
  logic [ADDR_BITS-1:0]   pred_tgt_chain [ENTRIES+1];
  logic [ENTRIES-1:0]     fill_sel;
  logic [ENTRIES-1:0]     tok_valid;

  logic                   accept;
  logic                   stall;
  logic                   xfer;
  logic                   fill_any;
  logic [ADDR_BITS-1:0]   pc_inc;

  logic                   busy_q;
  logic                   out_valid_q;
  logic                   hit_q;
  logic [15:0]            pred_q;
  logic [PtrW-1:0]        ptr_q, ptr_d;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // Head of the row: a fresh token from the input beat.
  always_comb begin
    ctl_chain[0]            = '0;
    ctl_chain[0].valid      = accept;
    ctl_chain[0].update     = operation_i;
    ctl_chain[0].taken      = taken_i;
    pc_chain[0]             = ADDR_BITS'(branch_pc_i);
    tgt_chain[0]            = ADDR_BITS'(target_pc_i);
    pred_tgt_chain[0]       = '0;
  end

  // Hold the token in the last cell while the output register is full.
  assign stall    = ctl_chain[ENTRIES].valid && out_valid_q && !out_ready_i;
  assign xfer     = ctl_chain[ENTRIES].valid && !stall;
  assign fill_any = xfer && (ctl_chain[ENTRIES].update == btb2b_pkg::OpUpdate)
                    && !ctl_chain[ENTRIES].hit;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    assign fill_sel[k]  = fill_any && (ptr_q == PtrW'(k));
    assign tok_valid[k] = ctl_chain[k+1].valid;

    btb2b_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .hold_i      ((k == ENTRIES - 1) ? stall : 1'b0),
      .ctl_i       (ctl_chain[k]),
      .pc_i        (pc_chain[k]),
      .tgt_i       (tgt_chain[k]),
      .pred_tgt_i  (pred_tgt_chain[k]),
      .ctl_o       (ctl_chain[k+1]),
      .pc_o        (pc_chain[k+1]),
      .tgt_o       (tgt_chain[k+1]),
      .pred_tgt_o  (pred_tgt_chain[k+1]),
      .fill_i      (fill_sel[k]),
      .fill_pc_i   (pc_chain[ENTRIES]),
      .fill_tgt_i  (tgt_chain[ENTRIES]),
      .fill_taken_i(ctl_chain[ENTRIES].taken)
    );
  end

  assign pc_inc = pc_chain[ENTRIES] + 1'b1;

  always_comb begin
    ptr_d = ptr_q;
    if (fill_any) begin
      ptr_d = (ptr_q == PtrW'(ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
    end else begin
      ptr_q <= ptr_d;
      priority if (accept) begin
        busy_q <= 1'b1;
      end else if (xfer) begin
        busy_q <= 1'b0;
      end
      priority if (xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      hit_q  <= ctl_chain[ENTRIES].hit;
      pred_q <= 16'(ctl_chain[ENTRIES].pred_taken ? pred_tgt_chain[ENTRIES] : pc_inc);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign predicted_pc_o = pred_q;

  `BTB2B_ASSERT_IMPL(a_one_token, 1'b1, $onehot0(tok_valid), "more than one token in row")
  `BTB2B_ASSERT_IMPL(a_idle_empty, !busy_q, tok_valid == '0, "token in row while idle")
  `BTB2B_ASSERT_NEXT(a_accept_head, accept, ctl_chain[1].valid, "accepted beat missing")
  `BTB2B_ASSERT_NEXT(a_xfer_out, xfer, out_valid_q, "result beat not registered")
  `BTB2B_ASSERT_IMPL(a_one_fill, 1'b1, $onehot0(fill_sel), "more than one entry filled")

endmodule

// ===== tb/sv/branch_target_buffer_2bit_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_target_buffer_2bit_unit_tb
// Drives predict and update beats into the branch target buffer and checks
// every result against a predictor of the eight-entry buffer. A short
// directed run covers counter saturation, address wrap and round-robin
// eviction. Random training bursts then follow over three pacing modes and
// one long output hold-off.
// ----------------------------------------------------------------------------
module branch_target_buffer_2bit_unit_tb;

  localparam int NumEntries    = 8;
  localparam int RandomBeats   = 550;
  localparam int PoolSize      = 12;
  localparam int HoldOffCycles = 80;
  localparam int CycleLimit    = 200000;

  typedef struct packed {
    logic        op;
    logic [15:0] pc;
    logic [15:0] tgt;
    logic        tk;
  } branch_req_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] next_pc;
  } btb_resp_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        operation_i    = btb2b_pkg::OpPredict;
  logic [15:0] branch_pc_i    = '0;
  logic [15:0] target_pc_i    = '0;
  logic        taken_i        = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        hit_o;
  logic [15:0] predicted_pc_o;

  branch_req_t pending_q[$];
  btb_resp_t   expected_q[$];

  // Predictor copy of the buffer
  logic        btb_valid  [NumEntries];
  logic [15:0] btb_branch [NumEntries];
  logic [15:0] btb_target [NumEntries];
  logic [1:0]  btb_ctr    [NumEntries];
  int          btb_victim;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_in      = 0;
  int beats_out     = 0;
  int hits_seen     = 0;
  int updates_seen  = 0;
  int fail_count    = 0;
  int cycle_count   = 0;
  int hold_left     = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;

  branch_target_buffer_2bit_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .branch_pc_i    (branch_pc_i),
    .target_pc_i    (target_pc_i),
    .taken_i        (taken_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .predicted_pc_o (predicted_pc_o)
  );

  always #6 clk_i = ~clk_i;

  // Look up first, then train on an update; the lowest matching index wins.
  function automatic btb_resp_t btb_lookup_train(branch_req_t req);
    btb_resp_t resp;
    int        idx;
    idx = -1;
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (btb_valid[i] && btb_branch[i] == req.pc) idx = i;
    end
    resp.hit = (idx >= 0);
    if (idx >= 0 && btb_ctr[idx] >= 2'd2) resp.next_pc = btb_target[idx];
    else resp.next_pc = req.pc + 16'd1;
    if (req.op == btb2b_pkg::OpUpdate) begin
      if (idx < 0) begin
        btb_valid[btb_victim]  = 1'b1;
        btb_branch[btb_victim] = req.pc;
        btb_target[btb_victim] = req.tgt;
        btb_ctr[btb_victim]    = req.tk ? btb2b_pkg::CtrMax : btb2b_pkg::CtrMin;
        btb_victim             = (btb_victim + 1) % NumEntries;
      end else begin
        btb_target[idx] = req.tgt;
        if (req.tk && btb_ctr[idx] != btb2b_pkg::CtrMax) begin
          btb_ctr[idx] = btb_ctr[idx] + 2'd1;
        end else if (!req.tk && btb_ctr[idx] != btb2b_pkg::CtrMin) begin
          btb_ctr[idx] = btb_ctr[idx] - 2'd1;
        end
      end
    end
    return resp;
  endfunction

  task automatic queue_beat(logic op, logic [15:0] pc, logic [15:0] tgt, logic tk);
    branch_req_t req;
    req.op  = op;
    req.pc  = pc;
    req.tgt = tgt;
    req.tk  = tk;
    pending_q.push_back(req);
  endtask

  // Sender: predict on acceptance, hold the beat while stalled.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    branch_req_t cur;
    branch_req_t nxt;
    btb_resp_t   resp;
    logic        offer;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= btb2b_pkg::OpPredict;
      branch_pc_i <= '0;
      target_pc_i <= '0;
      taken_i     <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cur.op  = operation_i;
        cur.pc  = branch_pc_i;
        cur.tgt = target_pc_i;
        cur.tk  = taken_i;
        resp    = btb_lookup_train(cur);
        expected_q.push_back(resp);
        beats_in++;
        if (resp.hit) hits_seen++;
        if (cur.op == btb2b_pkg::OpUpdate) updates_seen++;
      end
      if (!in_valid_i || in_ready_o) begin
        offer = (pending_q.size() != 0) && ($urandom_range(1, 100) > send_idle_pct);
        if (offer) begin
          nxt = pending_q.pop_front();
          operation_i <= nxt.op;
          branch_pc_i <= nxt.pc;
          target_pc_i <= nxt.tgt;
          taken_i     <= nxt.tk;
        end
        in_valid_i <= offer;
      end
    end
  end

  // Receiver: compare each result beat with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : observe
    btb_resp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no prediction pending");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          beats_out++;
          if (hit_o !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit_o);
            fail_count++;
          end
          if (predicted_pc_o !== want.next_pc) begin
            $error("predicted_pc: expected %04h, got %04h", want.next_pc, predicted_pc_o);
            fail_count++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HoldOffCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(1, 100) > recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [15:0] pc_pool [PoolSize];
    logic [15:0] pc;
    int          total;
    int          first_random;
    int          pick;

    for (int i = 0; i < NumEntries; i++) btb_valid[i] = 1'b0;
    btb_victim = 0;

    // Directed: wrap of pc+1, counter walk through both saturation points,
    // fields ignored on predict, and eviction after the pointer wraps.
    queue_beat(btb2b_pkg::OpPredict, 16'h0000, 16'hFFFF, 1'b1);
    queue_beat(btb2b_pkg::OpPredict, 16'hFFFF, 16'h0000, 1'b0);
    queue_beat(btb2b_pkg::OpUpdate,  16'hFFFF, 16'h8001, 1'b1);
    queue_beat(btb2b_pkg::OpPredict, 16'hFFFF, 16'h0000, 1'b0);
    queue_beat(btb2b_pkg::OpUpdate,  16'hFFFF, 16'h7FFE, 1'b0);
    queue_beat(btb2b_pkg::OpPredict, 16'hFFFF, 16'h0000, 1'b0);
    queue_beat(btb2b_pkg::OpUpdate,  16'hFFFF, 16'h5555, 1'b0);
    queue_beat(btb2b_pkg::OpPredict, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_beat(btb2b_pkg::OpUpdate,  16'hFFFF, 16'h5555, 1'b0);
    queue_beat(btb2b_pkg::OpUpdate,  16'hFFFF, 16'h5555, 1'b0);
    queue_beat(btb2b_pkg::OpUpdate,  16'hFFFF, 16'hAAAA, 1'b1);
    queue_beat(btb2b_pkg::OpUpdate,  16'hFFFF, 16'hAAAA, 1'b1);
    queue_beat(btb2b_pkg::OpUpdate,  16'hFFFF, 16'hFFFF, 1'b1);
    queue_beat(btb2b_pkg::OpUpdate,  16'hFFFF, 16'h0000, 1'b1);
    queue_beat(btb2b_pkg::OpUpdate,  16'hAAAA, 16'h5555, 1'b0);
    queue_beat(btb2b_pkg::OpPredict, 16'hAAAA, 16'h0000, 1'b0);
    for (int i = 0; i < NumEntries; i++) begin
      queue_beat(btb2b_pkg::OpUpdate, 16'h0100 + 16'(i), ~(16'h0100 + 16'(i)), i[0]);
    end
    queue_beat(btb2b_pkg::OpPredict, 16'hFFFF, 16'h0000, 1'b0);

    // Random: mostly training bursts on a pool larger than the buffer,
    // with unrelated beats mixed in.
    for (int i = 0; i < PoolSize; i++) pc_pool[i] = 16'($urandom_range(0, 16'hFFFF));
    first_random = pending_q.size();
    while (pending_q.size() - first_random < RandomBeats) begin
      pick = $urandom_range(0, 9);
      pc   = pc_pool[$urandom_range(0, PoolSize - 1)];
      if (pick < 7) begin
        queue_beat(btb2b_pkg::OpPredict, pc, 16'($urandom), 1'($urandom));
        repeat ($urandom_range(1, 4)) begin
          queue_beat(btb2b_pkg::OpUpdate, pc, 16'($urandom), 1'($urandom));
        end
        queue_beat(btb2b_pkg::OpPredict, pc, 16'($urandom), 1'($urandom));
      end else if (pick < 9) begin
        queue_beat(1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        queue_beat(btb2b_pkg::OpPredict, 16'($urandom), 16'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 15) == 0) pc_pool[$urandom_range(0, PoolSize - 1)] = 16'($urandom);
    end
    total = pending_q.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 76;
    while (beats_in < total / 3) @(negedge clk_i);
    send_idle_pct = 76;
    recv_idle_pct = 21;
    while (beats_in < 2 * total / 3) @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;

    while (pending_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (4 * (NumEntries + 1)) @(negedge clk_i);

    if (expected_q.size() != 0) begin
      $error("%0d predicted results never arrived", expected_q.size());
      fail_count++;
    end

    $display("Sent %0d beats (%0d updates), %0d looked up an existing entry; %0d results checked",
             beats_in, updates_seen, hits_seen, beats_out);
    $display("Pacing covered slow sender, slow receiver, full rate and a %0d-cycle output stall",
             HoldOffCycles);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/btb2b_pkg.sv
design/btb2b_cell.sv
design/branch_target_buffer_2bit_unit.sv
tb/sv/branch_target_buffer_2bit_unit_tb.sv
